### sv/tamv_pkg.sv
// ----------------------------------------------------------------------------
// Triangle affine map velocity package
// Shared widths, types and the request and result payload structures.
// ----------------------------------------------------------------------------
`default_nettype none
package tamv_pkg;
    localparam int FRAC_BITS = 16;
    localparam int DIMENSION = 2;
    localparam int W_COORD   = 32;
    localparam int W_DIFF    = W_COORD + 1;
    localparam int W_PROD    = 2 * W_DIFF;
    localparam int W_DET     = W_PROD + 1;
    localparam int W_NUM     = W_DET + FRAC_BITS;
    localparam int W_QUO     = W_NUM;
    localparam int QUO_STEPS = W_QUO;

    typedef struct packed {
        logic signed [W_COORD-1:0] old_center_x;
        logic signed [W_COORD-1:0] old_center_y;
        logic signed [W_COORD-1:0] new_center_x;
        logic signed [W_COORD-1:0] new_center_y;
        logic signed [W_COORD-1:0] old_node_a_x;
        logic signed [W_COORD-1:0] old_node_a_y;
        logic signed [W_COORD-1:0] old_node_b_x;
        logic signed [W_COORD-1:0] old_node_b_y;
        logic signed [W_COORD-1:0] new_node_a_x;
        logic signed [W_COORD-1:0] new_node_a_y;
        logic signed [W_COORD-1:0] new_node_b_x;
        logic signed [W_COORD-1:0] new_node_b_y;
    } t_tri;

    typedef struct packed {
        logic signed [W_COORD-1:0] shift_x;
        logic signed [W_COORD-1:0] shift_y;
        logic signed [W_COORD-1:0] grad_xx;
        logic signed [W_COORD-1:0] grad_xy;
        logic signed [W_COORD-1:0] grad_yx;
        logic signed [W_COORD-1:0] grad_yy;
        logic                      degenerate;
    } t_vel;
endpackage
`default_nettype wire

### sv/tamv_if.sv
// ----------------------------------------------------------------------------
// Triangle affine map velocity channels
// Valid and ready channels for the triangle requests and velocity results.
// ----------------------------------------------------------------------------
`default_nettype none
interface tamv_tri_if import tamv_pkg::*; ();
    logic valid;
    logic ready;
    t_tri data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tamv_vel_if import tamv_pkg::*; ();
    logic valid;
    logic ready;
    t_vel data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### sv/triangle_affine_map_velocity.sv
// ----------------------------------------------------------------------------
// Triangle affine map velocity
// Velocity of the affine map between an old and a new triangle.
// ----------------------------------------------------------------------------
// Each request on i_tri carries a centroid and two face nodes on the old and
// on the new mesh, in signed Q16.16. The block returns one velocity map per
// request on o_vel: the shift and the gradient J minus the identity, with a
// degenerate flag and zero values when the old triangle has no area.
// Throughput is one request per cycle unless o_vel stalls. The pipeline has
// 91 register stages: three for the differences, products and determinant,
// 85 in the bit-per-stage dividers for J, and three for the shift products,
// the shift sum and the final rounding. The whole pipeline advances together;
// when the receiver holds ready low with a result waiting, every stage holds
// and i_tri.ready falls, so nothing is lost or repeated. Reset clears all
// valid bits; payload is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
module triangle_affine_map_velocity import tamv_pkg::*; (
    input wire logic i_clk,
    input wire logic i_rst_n,
    tamv_tri_if.sink   i_tri,
    tamv_vel_if.source o_vel
);
    localparam int DIV_LAT = QUO_STEPS + 2;

    logic n_en;
    assign n_en = !o_vel.valid || o_vel.ready;
    assign i_tri.ready = n_en;

    // Stage 1: differences.
    logic signed [W_DIFF-1:0] r_a00, r_a01, r_a10, r_a11;
    logic signed [W_DIFF-1:0] r_b00, r_b01, r_b10, r_b11;
    logic signed [W_COORD-1:0] r1_c0x, r1_c0y, r1_c1x, r1_c1y;
    logic r1_v;
    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_a00 <= W_DIFF'(i_tri.data.old_node_a_x) - W_DIFF'(i_tri.data.old_center_x);
            r_a01 <= W_DIFF'(i_tri.data.old_node_b_x) - W_DIFF'(i_tri.data.old_center_x);
            r_a10 <= W_DIFF'(i_tri.data.old_node_a_y) - W_DIFF'(i_tri.data.old_center_y);
            r_a11 <= W_DIFF'(i_tri.data.old_node_b_y) - W_DIFF'(i_tri.data.old_center_y);
            r_b00 <= W_DIFF'(i_tri.data.new_node_a_x) - W_DIFF'(i_tri.data.new_center_x);
            r_b01 <= W_DIFF'(i_tri.data.new_node_b_x) - W_DIFF'(i_tri.data.new_center_x);
            r_b10 <= W_DIFF'(i_tri.data.new_node_a_y) - W_DIFF'(i_tri.data.new_center_y);
            r_b11 <= W_DIFF'(i_tri.data.new_node_b_y) - W_DIFF'(i_tri.data.new_center_y);
            r1_c0x <= i_tri.data.old_center_x;
            r1_c0y <= i_tri.data.old_center_y;
            r1_c1x <= i_tri.data.new_center_x;
            r1_c1y <= i_tri.data.new_center_y;
        end
    end

    // Stage 2: products for the determinant and the adjugate rows.
    logic signed [W_PROD-1:0] r_pd0, r_pd1;
    logic signed [W_PROD-1:0] r_p [8];
    logic signed [W_COORD-1:0] r2_c0x, r2_c0y, r2_c1x, r2_c1y;
    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_pd0 <= W_PROD'(r_a00) * W_PROD'(r_a11);
            r_pd1 <= W_PROD'(r_a01) * W_PROD'(r_a10);
            // s(i,0) = b(i,0)*a11 - b(i,1)*a10 ; s(i,1) = b(i,1)*a00 - b(i,0)*a01
            r_p[0] <= W_PROD'(r_b00) * W_PROD'(r_a11);
            r_p[1] <= W_PROD'(r_b01) * W_PROD'(r_a10);
            r_p[2] <= W_PROD'(r_b01) * W_PROD'(r_a00);
            r_p[3] <= W_PROD'(r_b00) * W_PROD'(r_a01);
            r_p[4] <= W_PROD'(r_b10) * W_PROD'(r_a11);
            r_p[5] <= W_PROD'(r_b11) * W_PROD'(r_a10);
            r_p[6] <= W_PROD'(r_b11) * W_PROD'(r_a00);
            r_p[7] <= W_PROD'(r_b10) * W_PROD'(r_a01);
            r2_c0x <= r1_c0x;
            r2_c0y <= r1_c0y;
            r2_c1x <= r1_c1x;
            r2_c1y <= r1_c1y;
        end
    end

    // Stage 3: determinant and numerators.
    logic signed [W_DET-1:0] r_det;
    logic signed [W_NUM-1:0] r_num [4];
    logic signed [W_COORD-1:0] r3_c0x, r3_c0y, r3_c1x, r3_c1y;
    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_det <= W_DET'(r_pd0) - W_DET'(r_pd1);
            for (int k = 0; k < 4; k++) begin
                r_num[k] <= W_NUM'(W_DET'(r_p[2*k]) - W_DET'(r_p[2*k+1])) <<< FRAC_BITS;
            end
            r3_c0x <= r2_c0x;
            r3_c0y <= r2_c0y;
            r3_c1x <= r2_c1x;
            r3_c1y <= r2_c1y;
        end
    end

    logic signed [W_COORD-1:0] n_jac [4];
    for (genvar k = 0; k < 4; k++) begin : g_div
        tamv_div u_div (
            .i_clk (i_clk),
            .i_en  (n_en),
            .i_num (r_num[k]),
            .i_den (r_det),
            .o_quo (n_jac[k])
        );
    end

    // Side delay line for the centroids and the degenerate flag.
    logic [4*W_COORD:0] r_dly [DIV_LAT];
    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_dly[0] <= {r3_c0x, r3_c0y, r3_c1x, r3_c1y, r_det == '0};
            for (int k = 1; k < DIV_LAT; k++) begin
                r_dly[k] <= r_dly[k-1];
            end
        end
    end

    logic signed [W_COORD-1:0] n_c0x, n_c0y, n_c1x, n_c1y;
    logic n_dg;
    assign {n_c0x, n_c0y, n_c1x, n_c1y, n_dg} = r_dly[DIV_LAT-1];

    // Stage M: J times centroid products.
    localparam int W_JM = 2 * W_COORD;
    localparam int W_S  = W_JM + 2;
    logic signed [W_JM-1:0] r_m0, r_m1, r_m2, r_m3;
    logic signed [W_COORD-1:0] rm_j [4];
    logic signed [W_COORD-1:0] rm_c1x, rm_c1y;
    logic rm_dg;
    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_m0 <= W_JM'(n_jac[0]) * W_JM'(n_c0x);
            r_m1 <= W_JM'(n_jac[1]) * W_JM'(n_c0y);
            r_m2 <= W_JM'(n_jac[2]) * W_JM'(n_c0x);
            r_m3 <= W_JM'(n_jac[3]) * W_JM'(n_c0y);
            rm_j <= n_jac;
            rm_c1x <= n_c1x;
            rm_c1y <= n_c1y;
            rm_dg  <= n_dg;
        end
    end

    // Stage S: shift numerator and gradients.
    logic signed [W_S-1:0] r_sx, r_sy;
    logic signed [W_COORD-1:0] rs_j [4];
    logic rs_dg;
    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_sx <= (W_S'(rm_c1x) <<< FRAC_BITS) - W_S'(r_m0) - W_S'(r_m1);
            r_sy <= (W_S'(rm_c1y) <<< FRAC_BITS) - W_S'(r_m2) - W_S'(r_m3);
            rs_j  <= rm_j;
            rs_dg <= rm_dg;
        end
    end

    function automatic logic signed [W_COORD-1:0] f_sat(input logic signed [W_S-1:0] v);
        logic signed [W_S-1:0] lo;
        logic signed [W_S-1:0] hi;
        lo = -(W_S'(1) <<< (W_COORD-1));
        hi = (W_S'(1) <<< (W_COORD-1)) - W_S'(1);
        if (v < lo) begin
            return {1'b1, {(W_COORD-1){1'b0}}};
        end else if (v > hi) begin
            return {1'b0, {(W_COORD-1){1'b1}}};
        end
        return W_COORD'(v);
    endfunction

    function automatic logic signed [W_COORD-1:0] f_rnd(input logic signed [W_S-1:0] v);
        logic [W_S-1:0] mag;
        logic [W_S-1:0] q;
        mag = v[W_S-1] ? W_S'(-v) : W_S'(v);
        q = (mag + (W_S'(1) << (FRAC_BITS-1))) >> FRAC_BITS;
        return f_sat(v[W_S-1] ? W_S'(-$signed(q)) : $signed(q));
    endfunction

    localparam logic signed [W_S-1:0] ONE = W_S'(1) <<< FRAC_BITS;

    t_vel r_out;
    logic r_ov;
    always_ff @(posedge i_clk) begin
        if (n_en) begin
            if (rs_dg) begin
                r_out.shift_x    <= '0;
                r_out.shift_y    <= '0;
                r_out.grad_xx    <= '0;
                r_out.grad_xy    <= '0;
                r_out.grad_yx    <= '0;
                r_out.grad_yy    <= '0;
                r_out.degenerate <= 1'b1;
            end else begin
                r_out.shift_x <= f_rnd(r_sx);
                r_out.shift_y <= f_rnd(r_sy);
                r_out.grad_xx <= f_sat(W_S'(rs_j[0]) - ONE);
                r_out.grad_xy <= rs_j[1];
                r_out.grad_yx <= rs_j[2];
                r_out.grad_yy <= f_sat(W_S'(rs_j[3]) - ONE);
                r_out.degenerate <= 1'b0;
            end
        end
    end

    // Valid bits travel alongside the data.
    localparam int N_V = 3 + DIV_LAT + 3;
    logic [N_V-1:0] r_v;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (n_en) begin
            r_v <= {r_v[N_V-2:0], i_tri.valid};
        end
    end
    assign r1_v  = r_v[0];
    assign r_ov  = r_v[N_V-1];

    assign o_vel.valid = r_ov;
    assign o_vel.data  = r_out;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vel.valid && !o_vel.ready |=> o_vel.valid && $stable(o_vel.data))
        else $error("result changed under stall");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_vel.valid |-> i_tri.ready)
        else $error("pipeline stalled while empty at output");
    a_degz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vel.valid && o_vel.data.degenerate |-> o_vel.data.shift_x == '0)
        else $error("degenerate result not zero");
    a_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_en && r1_v |=> r_v[1])
        else $error("valid bit lost");
endmodule
`default_nettype wire

### sv/tamv_div.sv
// ----------------------------------------------------------------------------
// Triangle affine map velocity divider
// Pipelined signed restoring divider, one quotient bit per stage, rounding
// to nearest with ties away from zero and saturating to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none
module tamv_div import tamv_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic signed [W_NUM-1:0]  i_num,
    input  wire logic signed [W_DET-1:0]  i_den,
    output      logic signed [W_COORD-1:0] o_quo
);
    localparam int WR = W_DET + 1;

    logic [W_NUM-1:0] r_n   [QUO_STEPS+1];
    logic [W_DET-1:0] r_d   [QUO_STEPS+1];
    logic [WR-1:0]    r_rem [QUO_STEPS+1];
    logic [W_QUO-1:0] r_q   [QUO_STEPS+1];
    logic             r_neg [QUO_STEPS+1];
    logic signed [W_COORD-1:0] r_out;

    logic [W_NUM-1:0] n_abs_n;
    logic [W_DET-1:0] n_abs_d;

    always_comb begin
        n_abs_n = i_num[W_NUM-1] ? W_NUM'(-i_num) : W_NUM'(i_num);
        n_abs_d = i_den[W_DET-1] ? W_DET'(-i_den) : W_DET'(i_den);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n[0]   <= n_abs_n;
            r_d[0]   <= n_abs_d;
            r_rem[0] <= '0;
            r_q[0]   <= '0;
            r_neg[0] <= i_num[W_NUM-1] ^ i_den[W_DET-1];
        end
    end

    for (genvar k = 0; k < QUO_STEPS; k++) begin : g_step
        logic [WR:0] n_try;
        logic [WR:0] n_sub;
        always_comb begin
            n_try = {r_rem[k], r_n[k][W_NUM-1-k]};
            n_sub = n_try - {2'b00, r_d[k]};
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[k+1]   <= r_n[k];
                r_d[k+1]   <= r_d[k];
                r_neg[k+1] <= r_neg[k];
                if (!n_sub[WR]) begin
                    r_rem[k+1] <= n_sub[WR-1:0];
                    r_q[k+1]   <= {r_q[k][W_QUO-2:0], 1'b1};
                end else begin
                    r_rem[k+1] <= n_try[WR-1:0];
                    r_q[k+1]   <= {r_q[k][W_QUO-2:0], 1'b0};
                end
            end
        end
    end

    logic [W_QUO:0]   n_qr;
    logic [WR:0]      n_rem2;
    logic             n_big;
    always_comb begin
        n_rem2 = {r_rem[QUO_STEPS], 1'b0};
        n_qr   = {1'b0, r_q[QUO_STEPS]} +
                 ((n_rem2 >= {2'b00, r_d[QUO_STEPS]}) ? (W_QUO+1)'(1) : '0);
        n_big  = r_neg[QUO_STEPS] ? (n_qr > (W_QUO+1)'(33'h080000000))
                                  : (n_qr > (W_QUO+1)'(32'h7fffffff));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (n_big) begin
                r_out <= r_neg[QUO_STEPS] ? 32'sh80000000 : 32'sh7fffffff;
            end else if (r_neg[QUO_STEPS]) begin
                r_out <= W_COORD'(-n_qr);
            end else begin
                r_out <= W_COORD'(n_qr);
            end
        end
    end

    assign o_quo = r_out;
endmodule
`default_nettype wire
